>>> rtl/psh_pkg.sv
// shared types and constants for the positioner homing supervisor
// no dependencies; every other file imports this package
package psh_pkg;

  localparam int ANGLE_FRACTION_BITS = 6;
  localparam int ANGLE_RAW_LIMIT = 360 << ANGLE_FRACTION_BITS;
  localparam int ANGLE_LIMIT = (ANGLE_RAW_LIMIT > 32767) ? 32767 : ANGLE_RAW_LIMIT;

  // divider widths: dividend and divisor magnitudes
  localparam int DIV_W = 53;
  localparam int DVS_W = 35;

  localparam logic [15:0] CW_CLEARFAULT = 16'h0080;
  localparam logic [15:0] CW_SHUTDOWN   = 16'h0006;
  localparam logic [15:0] CW_SWITCHON   = 16'h000F;
  localparam logic [15:0] CW_START      = 16'h003F;
  localparam logic [15:0] CW_HALFSTART  = 16'h001F;
  localparam logic [15:0] CW_RUNBITS    = 16'h0030;

  localparam int ST_FAULT_BIT   = 3;
  localparam int ST_REACHED_BIT = 10;
  localparam int ST_ERROR_BIT   = 13;
  localparam int ST_HOMED_BIT   = 15;

  localparam logic [7:0] OM_HOMING  = 8'd6;
  localparam logic [7:0] OM_PROFILE = 8'd1;

  localparam logic [1:0] OUT_DEFUNCT   = 2'd0;
  localparam logic [1:0] OUT_HOMING    = 2'd1;
  localparam logic [1:0] OUT_TARGETING = 2'd2;
  localparam logic [1:0] OUT_REACHED   = 2'd3;

  localparam logic [1:0] REG_HOME_ANGLE       = 2'd0;
  localparam logic [1:0] REG_EXTREME_ANGLE    = 2'd1;
  localparam logic [1:0] REG_HOME_POSITION    = 2'd2;
  localparam logic [1:0] REG_EXTREME_POSITION = 2'd3;

  typedef struct packed {
    logic signed [15:0] ha;
    logic signed [31:0] hp;
    logic signed [31:0] ep;
    logic signed [16:0] a;
    logic signed [32:0] p;
    logic               p_zero;
  } cfg_t;

  typedef struct packed {
    logic               need_math;
    logic               need_tol;
    logic [1:0]         outcome;
    logic               mw;
    logic [7:0]         mv;
    logic               cw;
    logic [7:0]         cv;
    logic               st_reached;
    logic               st_error;
    logic [15:0]        ctl;
    logic signed [31:0] pos;
    logic signed [31:0] targ;
    logic signed [15:0] wanted;
  } work_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic signed [15:0] angle;
    logic               valid;
    logic               mw;
    logic [7:0]         mv;
    logic               cw;
    logic [7:0]         cv;
    logic               tw;
    logic signed [31:0] tp;
  } res_t;

endpackage

>>> rtl/psh_cfg.sv
// configuration register file behind the apb-style port
// depends on psh_pkg; also keeps the derived angle and position spans
module psh_cfg
  import psh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic signed [15:0] ha_r, ea_r;
  logic signed [31:0] hp_r, ep_r;
  logic signed [16:0] a_r;
  logic signed [32:0] p_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ha_r <= 16'sd0;
      ea_r <= 16'sd23040;
      hp_r <= 32'sd0;
      ep_r <= 32'sd4096;
      a_r  <= 17'sd23040;
      p_r  <= 33'sd4096;
    end else begin
      if (wr_en) begin
        unique case (paddr[3:2])
          REG_HOME_ANGLE:       ha_r <= pwdata[15:0];
          REG_EXTREME_ANGLE:    ea_r <= pwdata[15:0];
          REG_HOME_POSITION:    hp_r <= pwdata;
          REG_EXTREME_POSITION: ep_r <= pwdata;
          default: ;
        endcase
      end
      // spans are registered from the registers and follow them in the next cycle
      a_r <= 17'(ea_r) - 17'(ha_r);
      p_r <= 33'(ep_r) - 33'(hp_r);
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HOME_ANGLE:       prdata = 32'(ha_r);
      REG_EXTREME_ANGLE:    prdata = 32'(ea_r);
      REG_HOME_POSITION:    prdata = hp_r;
      REG_EXTREME_POSITION: prdata = ep_r;
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg.ha     = ha_r;
  assign cfg.hp     = hp_r;
  assign cfg.ep     = ep_r;
  assign cfg.a      = a_r;
  assign cfg.p      = p_r;
  // the front may classify an item in the cycle right after a write
  assign cfg.p_zero = (ep_r == hp_r);

endmodule

>>> rtl/psh_front.sv
// front end: classifies one drive snapshot into a work record
// depends on psh_pkg; settles every case that needs no arithmetic
module psh_front
  import psh_pkg::*;
(
  input  cfg_t               cfg,
  input  logic               status_read_ok,
  input  logic               other_reads_ok,
  input  logic               setup_writes_ok,
  input  logic [15:0]        status_word,
  input  logic [15:0]        control_word,
  input  logic [7:0]         operating_mode,
  input  logic signed [31:0] current_position,
  input  logic signed [31:0] current_target,
  input  logic signed [15:0] wanted_angle,
  input  logic               wanted_given,
  output work_t              work
);

  always_comb begin
    work            = '0;
    work.st_reached = status_word[ST_REACHED_BIT];
    work.st_error   = status_word[ST_ERROR_BIT];
    work.ctl        = control_word;
    work.pos        = current_position;
    work.targ       = current_target;
    work.wanted     = wanted_angle;
    priority if (!status_read_ok) begin
    end else if (status_word[ST_FAULT_BIT]) begin
      work.cw = 1'b1;
      work.cv = CW_CLEARFAULT[7:0];
    end else if (!other_reads_ok) begin
    end else if (!setup_writes_ok) begin
      work.cw = 1'b1;
      work.cv = CW_SHUTDOWN[7:0];
    end else if (!status_word[ST_HOMED_BIT]) begin
      work.outcome = OUT_HOMING;
      priority if (operating_mode != OM_HOMING) begin
        work.mw = 1'b1; work.mv = OM_HOMING;
        work.cw = 1'b1; work.cv = CW_SHUTDOWN[7:0];
      end else if (control_word == CW_SHUTDOWN) begin
        work.cw = 1'b1; work.cv = CW_SWITCHON[7:0];
      end else if (control_word == CW_SWITCHON) begin
        work.cw = 1'b1; work.cv = CW_START[7:0];
      end else if (control_word == CW_START && !status_word[ST_ERROR_BIT]) begin
        // homing in progress
      end else begin
        work.mw = 1'b1; work.mv = OM_HOMING;
        work.cw = 1'b1; work.cv = CW_SHUTDOWN[7:0];
      end
    end else if (cfg.p_zero) begin
    end else begin
      work.need_math = 1'b1;
      priority if (operating_mode != OM_PROFILE) begin
        work.outcome = OUT_TARGETING;
        work.mw = 1'b1; work.mv = OM_PROFILE;
        work.cw = 1'b1; work.cv = CW_SHUTDOWN[7:0];
      end else if (!wanted_given) begin
        work.outcome = OUT_REACHED;
      end else begin
        work.need_tol = 1'b1;
      end
    end
  end

endmodule

>>> rtl/psh_queue.sv
// two-entry queue of work records between front and back end
// depends on psh_pkg for the record type
module psh_queue
  import psh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  work_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output work_t rd_data,
  output logic  empty
);

  work_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

>>> rtl/psh_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on psh_pkg for the operand widths
module psh_div
  import psh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/psh_back.sv
// back end: sequencer over one shared multiplier and the divider
// depends on psh_pkg, psh_div; holds the result register of the out channel
module psh_back
  import psh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  work_t q_data,
  output logic  q_pop,
  output res_t  out_res,
  output logic  out_valid,
  input  logic  out_pop
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_MUL  = 9'b000000010,
    B_ANG1 = 9'b000000100,
    B_ANG2 = 9'b000001000,
    B_DIVA = 9'b000010000,
    B_DEC  = 9'b000100000,
    B_TGT  = 9'b001000000,
    B_DIVT = 9'b010000000,
    B_OUT  = 9'b100000000
  } bstate_t;

  bstate_t            state_r;
  logic [2:0]         cnt_r;
  work_t              w_r;
  logic signed [32:0] d_pos_r, d_targ_r, d_pt_r;
  logic signed [16:0] d_w_r, n_adj_r;
  logic signed [33:0] abs_p_r;
  logic signed [17:0] abs_a_r;
  logic signed [51:0] pr_r [8];
  logic signed [52:0] nsum_r, dn_r, num_r;
  logic [52:0]        dn_mag_r, pt_mag_r;
  logic               far_t_r, far_a_r, neg_r;
  res_t               res_r, out_r;
  logic               out_valid_r;

  logic signed [33:0] mul_x;
  logic signed [17:0] mul_y;
  logic signed [51:0] prod;
  logic signed [52:0] nsum, nmag_s;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [DVS_W-1:0]   div_divisor;
  logic [15:0]        q_clamp;
  logic               reached_eff;
  logic [15:0]        ctl_eff;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (cnt_r)
      3'd0: begin mul_x = 34'(cfg.p);    mul_y = 18'(cfg.ha);  end
      3'd1: begin mul_x = 34'(d_pos_r);  mul_y = 18'(cfg.a);   end
      3'd2: begin mul_x = 34'(cfg.p);    mul_y = 18'(d_w_r);   end
      3'd3: begin mul_x = 34'(d_targ_r); mul_y = 18'(cfg.a);   end
      3'd4: begin mul_x = 34'(d_pt_r);   mul_y = 18'(cfg.a);   end
      3'd5: begin mul_x = abs_p_r;       mul_y = abs_a_r;      end
      3'd6: begin mul_x = 34'(cfg.hp);   mul_y = abs_a_r;      end
      default: begin mul_x = 34'(cfg.p); mul_y = 18'(n_adj_r); end
    endcase
  end

  assign prod   = mul_x * mul_y;
  assign nsum   = 53'(pr_r[0]) + 53'(pr_r[1]);
  assign nmag_s = (nsum_r < 0) ? -nsum_r : nsum_r;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (state_r == B_ANG2) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'({nmag_s, 1'b0}) + DIV_W'(abs_p_r);
      div_divisor  = DVS_W'({abs_p_r, 1'b0});
    end else if (state_r == B_TGT) begin
      div_start    = 1'b1;
      div_dividend = (num_r < 0) ? DIV_W'(-num_r) : DIV_W'(num_r);
      div_divisor  = DVS_W'(abs_a_r);
    end
  end

  psh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_clamp     = (div_q > DIV_W'(ANGLE_LIMIT)) ? 16'(ANGLE_LIMIT) : div_q[15:0];
  assign reached_eff = w_r.st_reached & ~far_t_r & ~far_a_r;
  assign ctl_eff     = far_t_r ? (w_r.ctl & ~CW_RUNBITS) : w_r.ctl;
  assign q_pop       = (state_r == B_IDLE) && !q_empty;
  assign out_res     = out_r;
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !q_empty) begin
      w_r            <= q_data;
      d_pos_r        <= 33'(q_data.pos) - 33'(cfg.hp);
      d_targ_r       <= 33'(q_data.targ) - 33'(cfg.hp);
      d_pt_r         <= 33'(q_data.pos) - 33'(q_data.targ);
      d_w_r          <= 17'(q_data.wanted) - 17'(cfg.ha);
      n_adj_r        <= (cfg.a < 0) ? 17'(cfg.ha) - 17'(q_data.wanted)
                                    : 17'(q_data.wanted) - 17'(cfg.ha);
      abs_p_r        <= (cfg.p < 0) ? -34'(cfg.p) : 34'(cfg.p);
      abs_a_r        <= (cfg.a < 0) ? -18'(cfg.a) : 18'(cfg.a);
      res_r.outcome  <= q_data.outcome;
      res_r.angle    <= 16'sd0;
      res_r.valid    <= q_data.need_math;
      res_r.mw       <= q_data.mw;
      res_r.mv       <= q_data.mv;
      res_r.cw       <= q_data.cw;
      res_r.cv       <= q_data.cv;
      res_r.tw       <= 1'b0;
      res_r.tp       <= 32'sd0;
    end
    if (state_r == B_MUL) pr_r[cnt_r] <= prod;
    if (state_r == B_ANG1) begin
      nsum_r <= (cfg.p < 0) ? -nsum : nsum;
      dn_r   <= 53'(pr_r[2]) - 53'(pr_r[3]);
      num_r  <= 53'(pr_r[6]) + 53'(pr_r[7]);
    end
    if (state_r == B_ANG2) begin
      neg_r    <= (nsum_r < 0);
      dn_mag_r <= (dn_r < 0) ? 53'(-dn_r) : 53'(dn_r);
      pt_mag_r <= (pr_r[4] < 0) ? 53'(-pr_r[4]) : 53'(pr_r[4]);
    end
    if (state_r == B_DIVA) begin
      far_t_r <= ({dn_mag_r, 8'd0} > 61'(pr_r[5]));
      far_a_r <= ({pt_mag_r, 8'd0} > 61'(pr_r[5]));
      if (div_done) res_r.angle <= neg_r ? -$signed(q_clamp) : $signed(q_clamp);
    end
    if (state_r == B_DEC && w_r.need_tol) begin
      if (reached_eff) begin
        res_r.outcome <= OUT_REACHED;
        res_r.cw <= 1'b1; res_r.cv <= CW_SHUTDOWN[7:0];
      end else begin
        res_r.outcome <= OUT_TARGETING;
        priority if (ctl_eff == CW_SHUTDOWN) begin
          res_r.cw <= 1'b1; res_r.cv <= CW_SWITCHON[7:0];
        end else if (ctl_eff == CW_SWITCHON) begin
          res_r.cw <= 1'b1; res_r.cv <= CW_START[7:0];
          res_r.tw <= 1'b1;
          // end points settle the target without a division
          priority if (cfg.a == 17'sd0) begin
            res_r.tp <= (d_w_r > 0) ? cfg.ep : cfg.hp;
          end else if (n_adj_r <= 0) begin
            res_r.tp <= cfg.hp;
          end else if (18'(n_adj_r) >= abs_a_r) begin
            res_r.tp <= cfg.ep;
          end else begin
            res_r.tp <= 32'sd0;
          end
        end else if ((ctl_eff == CW_START || ctl_eff == CW_HALFSTART) && !w_r.st_error) begin
          // moving
        end else begin
          res_r.mw <= 1'b1; res_r.mv <= OM_PROFILE;
          res_r.cw <= 1'b1; res_r.cv <= CW_SHUTDOWN[7:0];
        end
      end
    end
    if (state_r == B_TGT) neg_r <= (num_r < 0);
    if (state_r == B_DIVT && div_done)
      res_r.tp <= neg_r ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
    if (state_r == B_OUT && (!out_valid_r || out_pop)) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          cnt_r <= 3'd0;
          if (!q_empty) state_r <= q_data.need_math ? B_MUL : B_OUT;
        end
        B_MUL: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) state_r <= B_ANG1;
        end
        B_ANG1: state_r <= B_ANG2;
        B_ANG2: state_r <= B_DIVA;
        B_DIVA: if (div_done) state_r <= B_DEC;
        B_DEC: begin
          if (w_r.need_tol && !reached_eff && ctl_eff == CW_SWITCHON &&
              cfg.a != 17'sd0 && n_adj_r > 0 && 18'(n_adj_r) < abs_a_r)
            state_r <= B_TGT;
          else
            state_r <= B_OUT;
        end
        B_TGT:  state_r <= B_DIVT;
        B_DIVT: if (div_done) state_r <= B_OUT;
        B_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/positioner_homing_supervisor.sv
// top level of the positioner homing supervisor
// depends on psh_pkg, psh_cfg, psh_front, psh_queue, psh_back
//
//  channel  | handshake              | contents
//  ---------+------------------------+------------------------------------
//  in       | push / full            | one polled drive snapshot
//  out      | empty / pop            | outcome, angle and drive writes
//  config   | psel penable pwrite .. | end angles and counts at bytes 0, 4, 8, 12
//
// snapshots that need no arithmetic (faults, failed reads, homing) go
// straight to the back end's output stage; a homed snapshot with distinct
// end positions makes eight passes through the shared multiplier and one
// 53-step division, and a second when a new target has to be divided out.
// the front and a two-entry queue keep taking items while the back works, until the queue is full.
// reset is synchronous; no clearing pass is needed.
module positioner_homing_supervisor
  import psh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               in_status_read_ok,
  input  logic               in_other_reads_ok,
  input  logic               in_setup_writes_ok,
  input  logic [15:0]        in_status_word,
  input  logic [15:0]        in_control_word,
  input  logic [7:0]         in_operating_mode,
  input  logic signed [31:0] in_current_position,
  input  logic signed [31:0] in_current_target,
  input  logic signed [15:0] in_wanted_angle,
  input  logic               in_wanted_given,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_outcome,
  output logic signed [15:0] out_actual_angle,
  output logic               out_actual_valid,
  output logic               out_mode_write,
  output logic [7:0]         out_mode_value,
  output logic               out_control_write,
  output logic [7:0]         out_control_value,
  output logic               out_target_write,
  output logic signed [31:0] out_target_position
);

  cfg_t  cfg;
  work_t work, q_data;
  logic  q_full, q_empty, q_pop, out_valid;
  res_t  res;

  psh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psh_front u_front (
    .cfg              (cfg),
    .status_read_ok   (in_status_read_ok),
    .other_reads_ok   (in_other_reads_ok),
    .setup_writes_ok  (in_setup_writes_ok),
    .status_word      (in_status_word),
    .control_word     (in_control_word),
    .operating_mode   (in_operating_mode),
    .current_position (in_current_position),
    .current_target   (in_current_target),
    .wanted_angle     (in_wanted_angle),
    .wanted_given     (in_wanted_given),
    .work             (work)
  );

  psh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push & ~q_full),
    .wr_data (work),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  psh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_res   (res),
    .out_valid (out_valid),
    .out_pop   (pop)
  );

  assign full                = q_full;
  assign empty               = ~out_valid;
  assign out_outcome         = res.outcome;
  assign out_actual_angle    = res.angle;
  assign out_actual_valid    = res.valid;
  assign out_mode_write      = res.mw;
  assign out_mode_value      = res.mv;
  assign out_control_write   = res.cw;
  assign out_control_value   = res.cv;
  assign out_target_write    = res.tw;
  assign out_target_position = res.tp;

endmodule
